/* rtl/mkpq_pkg.sv */
// shared types, codes and ordering function of the multi-key priority queue
// no dependencies; used by mkpq_store and multi_key_priority_queue
package mkpq_pkg;

	localparam int MKPQ_CAPACITY = 16;

	// operation codes
	localparam logic [1:0] FUNC_PUSH = 2'd0;
	localparam logic [1:0] FUNC_POP  = 2'd1;
	localparam logic [1:0] FUNC_PEEK = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// kind codes
	localparam logic [1:0] KIND_SYSTEM  = 2'd0;
	localparam logic [1:0] KIND_MESSAGE = 2'd1;

	// kind ranks
	localparam logic [1:0] RANK_MESSAGE = 2'd3;
	localparam logic [1:0] RANK_SYSTEM  = 2'd2;
	localparam logic [1:0] RANK_OTHER   = 2'd1;

	typedef struct packed {
		logic [1:0]          func;
		logic [1:0]          kind;
		logic                urgent;
		logic signed [31:0]  timestamp;
		logic [31:0]         seq_number;
		logic [15:0]         payload_tag;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [1:0]          out_kind;
		logic                out_urgent;
		logic signed [31:0]  out_timestamp;
		logic [31:0]         out_seq_number;
		logic [15:0]         out_payload_tag;
		logic [4:0]          entry_count;
	} rsp_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic                urgent;
		logic signed [31:0]  timestamp;
		logic [31:0]         seq_number;
		logic [15:0]         payload_tag;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_SHIFT,
		ST_RESULT
	} state_t;

	function automatic logic [1:0] kind_rank(input logic [1:0] kind);
		logic [1:0] r;
		if (kind == KIND_MESSAGE) begin
			r = RANK_MESSAGE;
		end else if (kind == KIND_SYSTEM) begin
			r = RANK_SYSTEM;
		end else begin
			r = RANK_OTHER;
		end
		return r;
	endfunction

	// true when entry a strictly outranks entry b
	function automatic logic outranks(input entry_t a, input entry_t b);
		logic ua;
		logic ub;
		logic [1:0] ra;
		logic [1:0] rb;
		logic res;
		ua = (a.kind == KIND_SYSTEM) && a.urgent;
		ub = (b.kind == KIND_SYSTEM) && b.urgent;
		ra = kind_rank(a.kind);
		rb = kind_rank(b.kind);
		if (ua != ub) begin
			res = ua;
		end else if (a.timestamp != b.timestamp) begin
			res = $signed(a.timestamp) < $signed(b.timestamp);
		end else if (ra != rb) begin
			res = ra > rb;
		end else begin
			res = a.seq_number < b.seq_number;
		end
		return res;
	endfunction

endpackage

/* rtl/mkpq_store.sv */
// entry store of the priority queue: one write port, one registered read port
// depends on mkpq_pkg (entry_t)
module mkpq_store #(
	parameter int DEPTH = mkpq_pkg::MKPQ_CAPACITY,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  mkpq_pkg::entry_t    wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output mkpq_pkg::entry_t    rd_data
);
	import mkpq_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/multi_key_priority_queue.sv */
// top level of the multi-key priority queue: sequencer, one shared comparator
// depends on mkpq_pkg and mkpq_store
//
//   channel | signals                      | direction | payload
//   --------+------------------------------+-----------+---------------------
//   req     | req_valid, req_ready, req    | in        | op and entry fields
//   rsp     | rsp_valid, rsp_ready, rsp    | out       | status, entry, count
//
// push, unused op, pop or peek on empty: from accept straight to the result state
// peek: scan, pick and result states, one store read per entry through a single comparator
// pop: scan, pick, then a shift of the entries after the chosen one; the shift reuses the read port
// reset clears the sequencer, fill count and result valid; the store needs no clear
// req_ready is high only while the sequencer is idle; a held result does not
// block accepting the next item, only the next result load
module multi_key_priority_queue #(
	parameter int CAPACITY = mkpq_pkg::MKPQ_CAPACITY
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  mkpq_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output mkpq_pkg::rsp_t  rsp
);
	import mkpq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	// sequencer and control registers
	state_t         state_q, state_d;
	logic [CW-1:0]  fill_q, fill_d;
	logic [CW-1:0]  idx_q, idx_d;          // index of the read in flight
	logic [IW-1:0]  best_idx_q, best_idx_d;
	logic [1:0]     op_q, op_d;
	logic [1:0]     status_q, status_d;
	logic           sel_q, sel_d;          // result carries a selected entry
	logic           rsp_valid_q, rsp_valid_d;

	// payload registers
	entry_t         best_q, best_d;
	rsp_t           rsp_q, rsp_d;

	// store port
	logic           wr_en;
	logic [IW-1:0]  wr_addr;
	entry_t         wr_data;
	logic           rd_en;
	logic [IW-1:0]  rd_addr;
	entry_t         rd_data;

	logic           req_acc;
	logic           rsp_load;
	logic [CW-1:0]  idx_next;
	logic [CW-1:0]  best_next;
	logic [CW+4:0]  cnt_ext;
	entry_t         push_entry;

	mkpq_store #(
		.DEPTH (CAPACITY),
		.AW    (IW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign idx_next  = idx_q + CW'(1);
	assign best_next = CW'(best_idx_q) + CW'(1);
	// entry count is the fill masked to five bits
	assign cnt_ext   = {5'd0, fill_q};

	assign push_entry.kind        = req.kind;
	assign push_entry.urgent      = req.urgent;
	assign push_entry.timestamp   = req.timestamp;
	assign push_entry.seq_number  = req.seq_number;
	assign push_entry.payload_tag = req.payload_tag;

	// result register loads in the result state when empty or being drained
	assign rsp_load = (state_q == ST_RESULT) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			idx_q       <= '0;
			best_idx_q  <= '0;
			op_q        <= FUNC_PUSH;
			status_q    <= STAT_OK;
			sel_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			fill_q      <= fill_d;
			idx_q       <= idx_d;
			best_idx_q  <= best_idx_d;
			op_q        <= op_d;
			status_q    <= status_d;
			sel_q       <= sel_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		best_q <= best_d;
		rsp_q  <= rsp_d;
	end

	// next state, store control and result assembly
	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		idx_d       = idx_q;
		best_idx_d  = best_idx_q;
		op_d        = op_q;
		status_d    = status_q;
		sel_d       = sel_q;
		best_d      = best_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q;
		wr_en       = 1'b0;
		wr_addr     = fill_q[IW-1:0];
		wr_data     = push_entry;
		rd_en       = 1'b0;
		rd_addr     = '0;

		if (rsp_valid_q && rsp_ready) begin
			rsp_valid_d = 1'b0;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					op_d     = req.func;
					status_d = STAT_OK;
					sel_d    = 1'b0;
					state_d  = ST_RESULT;
					case (req.func) inside
						FUNC_PUSH: begin
							if (fill_q == CW'(CAPACITY)) begin
								status_d = STAT_FULL;
							end else begin
								// append at the end of the store
								wr_en  = 1'b1;
								fill_d = fill_q + CW'(1);
							end
						end
						FUNC_POP, FUNC_PEEK: begin
							if (fill_q == '0) begin
								status_d = STAT_EMPTY;
							end else begin
								// start the scan at entry zero
								rd_en   = 1'b1;
								rd_addr = '0;
								idx_d   = '0;
								sel_d   = 1'b1;
								state_d = ST_SCAN;
							end
						end
						default: begin
							// unused op code: no operation
						end
					endcase
				end
			end

			ST_SCAN: begin
				// shared comparator: entry in flight against current best
				if (idx_q == '0 || outranks(rd_data, best_q)) begin
					best_d     = rd_data;
					best_idx_d = idx_q[IW-1:0];
				end
				if (idx_next < fill_q) begin
					rd_en   = 1'b1;
					rd_addr = idx_next[IW-1:0];
					idx_d   = idx_next;
				end else begin
					state_d = ST_PICK;
				end
			end

			ST_PICK: begin
				if (op_q == FUNC_POP) begin
					if (best_next < fill_q) begin
						// first entry after the chosen one moves down
						rd_en   = 1'b1;
						rd_addr = best_next[IW-1:0];
						idx_d   = best_next;
						state_d = ST_SHIFT;
					end else begin
						fill_d  = fill_q - CW'(1);
						state_d = ST_RESULT;
					end
				end else begin
					state_d = ST_RESULT;
				end
			end

			ST_SHIFT: begin
				// write the entry read last cycle one place lower
				wr_en   = 1'b1;
				wr_addr = IW'(idx_q - CW'(1));
				wr_data = rd_data;
				if (idx_next < fill_q) begin
					rd_en   = 1'b1;
					rd_addr = idx_next[IW-1:0];
					idx_d   = idx_next;
				end else begin
					fill_d  = fill_q - CW'(1);
					state_d = ST_RESULT;
				end
			end

			ST_RESULT: begin
				if (rsp_load) begin
					rsp_d.status          = status_q;
					rsp_d.out_kind        = sel_q ? best_q.kind : 2'd0;
					rsp_d.out_urgent      = sel_q ? best_q.urgent : 1'b0;
					rsp_d.out_timestamp   = sel_q ? best_q.timestamp : 32'sd0;
					rsp_d.out_seq_number  = sel_q ? best_q.seq_number : 32'd0;
					rsp_d.out_payload_tag = sel_q ? best_q.payload_tag : 16'd0;
					rsp_d.entry_count     = cnt_ext[4:0];
					rsp_valid_d           = 1'b1;
					state_d               = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_idx_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_SHIFT) |-> idx_q < fill_q)
		else $error("store read beyond stored entries");

	a_pick_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PICK) |-> (fill_q != '0 && sel_q))
		else $error("selection with an empty store");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.func == FUNC_PUSH && fill_q != CW'(CAPACITY))
		|=> fill_q == $past(fill_q) + CW'(1))
		else $error("push did not grow the fill count");
`endif

endmodule

/* sim/multi_key_priority_queue_tb.sv */
// testbench for multi_key_priority_queue: directed and random push, pop and peek traffic,
// each result checked against a behavioral model of the linear-scan queue kept in the bench
// depends on mkpq_pkg and the multi_key_priority_queue rtl
module multi_key_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mkpq_pkg::*;

	// codes the package does not name
	localparam logic [1:0] KIND_APP   = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	// run limit, sized with every stall at its longest
	localparam int CYCLE_LIMIT = 1_500_000;
	// cycles the receiver refuses results during the backpressure test
	localparam int LONG_HOLD = 400;
	// quiet time at the end, longer than the slowest pop
	localparam int DRAIN_CYCLES = 60;

	logic   clk;
	logic   arst_n;
	logic   req_valid;
	logic   req_ready;
	req_t   req;
	logic   rsp_valid;
	logic   rsp_ready;
	rsp_t   rsp;

	// model of the stored entries in insertion order
	entry_t queue_model[$];
	// one expected result per accepted item, oldest first
	rsp_t   expected_results[$];

	// traffic shaping shared by sender and receiver
	bit     no_idle;
	bit     long_hold_req;
	int     hold_left;
	int     stall_left;

	// bookkeeping for the summary and the verdict
	int     mismatches;
	int     items_sent;
	int     results_checked;
	int     pushes_full;
	int     empty_reads;
	int     deepest_fill;
	int     cycle_count;

	multi_key_priority_queue DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// message ranks above system, everything else ranks lowest
	function automatic logic [1:0] kind_order(logic [1:0] kind);
		case (kind)
			KIND_MESSAGE: return RANK_MESSAGE;
			KIND_SYSTEM:  return RANK_SYSTEM;
			default:      return RANK_OTHER;
		endcase
	endfunction

	// strict precedence of a over b; a tie keeps the earlier stored entry
	function automatic bit takes_precedence(entry_t a, entry_t b);
		bit a_hot;
		bit b_hot;
		a_hot = (a.kind == KIND_SYSTEM) && a.urgent;
		b_hot = (b.kind == KIND_SYSTEM) && b.urgent;
		if (a_hot != b_hot) return a_hot;
		if (a.timestamp != b.timestamp) return $signed(a.timestamp) < $signed(b.timestamp);
		if (kind_order(a.kind) != kind_order(b.kind))
			return kind_order(a.kind) > kind_order(b.kind);
		return a.seq_number < b.seq_number;
	endfunction

	// apply one item to the model and return the result the block must give
	function automatic rsp_t predict_result(req_t item);
		rsp_t   r;
		entry_t e;
		int     best;
		r = '0;
		case (item.func) inside
			FUNC_PUSH: begin
				if (queue_model.size() >= MKPQ_CAPACITY) begin
					r.status = STAT_FULL;
					pushes_full++;
				end else begin
					e.kind        = item.kind;
					e.urgent      = item.urgent;
					e.timestamp   = item.timestamp;
					e.seq_number  = item.seq_number;
					e.payload_tag = item.payload_tag;
					queue_model.push_back(e);
				end
			end
			FUNC_POP, FUNC_PEEK: begin
				if (queue_model.size() == 0) begin
					r.status = STAT_EMPTY;
					empty_reads++;
				end else begin
					best = 0;
					for (int i = 1; i < queue_model.size(); i++)
						if (takes_precedence(queue_model[i], queue_model[best]))
							best = i;
					r.out_kind        = queue_model[best].kind;
					r.out_urgent      = queue_model[best].urgent;
					r.out_timestamp   = queue_model[best].timestamp;
					r.out_seq_number  = queue_model[best].seq_number;
					r.out_payload_tag = queue_model[best].payload_tag;
					if (item.func == FUNC_POP)
						queue_model.delete(best);
				end
			end
			default: ;
		endcase
		r.entry_count = 5'(queue_model.size());
		if (queue_model.size() > deepest_fill)
			deepest_fill = queue_model.size();
		return r;
	endfunction

	function automatic req_t make_item(logic [1:0] op, logic [1:0] kind, logic urgent,
		logic [31:0] ts, logic [31:0] seq, logic [15:0] tag);
		req_t it;
		it.func        = op;
		it.kind        = kind;
		it.urgent      = urgent;
		it.timestamp   = ts;
		it.seq_number  = seq;
		it.payload_tag = tag;
		return it;
	endfunction

	// random entry content, often squeezed into narrow ranges so ties happen
	function automatic req_t random_item(logic [1:0] op);
		logic [1:0]  kind;
		logic [31:0] ts;
		logic [31:0] seq;
		kind = ($urandom_range(0, 9) == 0) ? KIND_SPARE : 2'($urandom_range(0, 2));
		case ($urandom_range(0, 3))
			0, 1:    ts = $urandom();
			2:       ts = $urandom_range(0, 6) - 3;
			default: ts = ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
		seq = ($urandom_range(0, 1) == 1) ? $urandom() : $urandom_range(0, 3);
		return make_item(op, kind, 1'($urandom_range(0, 1)), ts, seq,
			16'($urandom_range(0, 65535)));
	endfunction

	// offer one item, hold it until accepted, then record what it must produce
	task automatic send_item(input req_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_ready !== 1'b1);
		expected_results.push_back(predict_result(item));
		items_sent++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// result side: check each accepted result, then decide ready for the next edge
	always @(posedge clk) begin : result_monitor
		rsp_t want;
		if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
			if (expected_results.size() == 0) begin
				$error("result arrived with no item outstanding");
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", 32'(want.status), 32'(rsp.status));
				check_field("out_kind", 32'(want.out_kind), 32'(rsp.out_kind));
				check_field("out_urgent", 32'(want.out_urgent), 32'(rsp.out_urgent));
				check_field("out_timestamp", want.out_timestamp, rsp.out_timestamp);
				check_field("out_seq_number", want.out_seq_number, rsp.out_seq_number);
				check_field("out_payload_tag", 32'(want.out_payload_tag),
					32'(rsp.out_payload_tag));
				check_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
				results_checked++;
			end
		end
		// a long hold is requested by the test and counted down here
		if (long_hold_req) begin
			hold_left     = LONG_HOLD;
			long_hold_req = 1'b0;
		end
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left--;
		end else begin
			rsp_ready <= 1'b1;
			if (!no_idle && $urandom_range(0, 99) < 25)
				stall_left = pick_gap();
		end
	end

	// reads on an empty queue and the unused op code
	task automatic test_empty_ops();
		send_item(make_item(FUNC_POP,  KIND_SYSTEM, 1'b0, '0, '0, '0));
		send_item(make_item(FUNC_PEEK, KIND_SYSTEM, 1'b0, '0, '0, '0));
		send_item(make_item(FUNC_NONE, KIND_SPARE,  1'b1, '1, '1, '1));
	endtask

	// every ordering key in turn, field extremes, ties broken by storage order
	task automatic test_ordering_rules();
		// urgent system wins despite the latest possible time
		send_item(make_item(FUNC_PUSH, KIND_SYSTEM,  1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF));
		// urgent message: flag stored but ignored for ordering
		send_item(make_item(FUNC_PUSH, KIND_MESSAGE, 1'b1, 32'h8000_0000, '0, 16'h0001));
		send_item(make_item(FUNC_PUSH, KIND_APP,     1'b0, 32'h8000_0000, '0, 16'h0002));
		// spare kind ranks like app, full tie with the app entry above
		send_item(make_item(FUNC_PUSH, KIND_SPARE,   1'b1, 32'h8000_0000, '0, 16'h0003));
		// full tie with the urgent message, which was stored first
		send_item(make_item(FUNC_PUSH, KIND_MESSAGE, 1'b0, 32'h8000_0000, '0, 16'h0004));
		send_item(make_item(FUNC_PUSH, KIND_SYSTEM,  1'b0, 32'h8000_0000, '0, 16'h0000));
		send_item(make_item(FUNC_NONE, KIND_SYSTEM,  1'b0, '0, '0, '0));
		send_item(make_item(FUNC_PEEK, KIND_SYSTEM,  1'b0, '0, '0, '0));
		repeat (7)
			send_item(make_item(FUNC_POP, KIND_SYSTEM, 1'b0, '0, '0, '0));
	endtask

	// receiver holds off while pushes keep coming: block fills, goes full, stalls its input
	task automatic test_full_backpressure();
		no_idle       = 1'b1;
		long_hold_req = 1'b1;
		repeat (MKPQ_CAPACITY + 4)
			send_item(random_item(FUNC_PUSH));
		no_idle = 1'b0;
		repeat (MKPQ_CAPACITY + 1)
			send_item(random_item(FUNC_POP));
	endtask

	// phases that lean toward filling, draining or a balance, some without idling
	task automatic test_random_mix(input int n_items);
		int         done;
		int         push_pct;
		int         r;
		logic [1:0] op;
		done = 0;
		while (done < n_items) begin
			case ($urandom_range(0, 2))
				0:       push_pct = 80;
				1:       push_pct = 50;
				default: push_pct = 20;
			endcase
			no_idle = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(10, 60)) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					op = FUNC_NONE;
				else if (r < 3 + push_pct)
					op = FUNC_PUSH;
				else if ($urandom_range(0, 2) == 0)
					op = FUNC_PEEK;
				else
					op = FUNC_POP;
				send_item(random_item(op));
				done++;
			end
		end
		no_idle = 1'b0;
	endtask

	// back-to-back traffic with the receiver starting no new stalls
	task automatic test_back_to_back(input int n_items);
		no_idle = 1'b1;
		repeat (n_items)
			send_item(random_item(($urandom_range(0, 1) == 1) ? FUNC_PUSH : FUNC_POP));
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_ops();
		test_ordering_rules();
		test_full_backpressure();
		test_random_mix(1500);
		test_back_to_back(100);

		// all items accepted: wait for the last results, then a quiet stretch
		req_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items sent, %0d results checked, %0d mismatches", items_sent,
			results_checked, mismatches);
		$display("%0d pushes refused as full, %0d reads on empty, deepest fill %0d",
			pushes_full, empty_reads, deepest_fill);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/mkpq_pkg.sv
rtl/mkpq_store.sv
rtl/multi_key_priority_queue.sv
sim/multi_key_priority_queue_tb.sv
